### design/lsfh_pkg.sv
// ----------------------------------------------------------------------------
// lsfh_pkg: shared types and codes for the link set-up frame handshake
// Frame layout, input and result codes, register indexes, config and
// burst descriptor structs.
// ----------------------------------------------------------------------------
package lsfh_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL  = 3'd4;

    // register reset values
    localparam logic        ROLE_RST     = 1'b0;
    localparam logic [15:0] TIMEOUT_RST  = 16'd3;
    localparam logic [3:0]  MAX_TRY_RST  = 4'd3;
    localparam logic [7:0]  ADDRESS_RST  = 8'h03;
    localparam logic [7:0]  CONTROL_RST  = 8'h03;

    localparam logic ROLE_TX = 1'b0;
    localparam logic ROLE_RX = 1'b1;

    // input item codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_EST  = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // status report attached to a burst (none shares the tx code value)
    localparam logic [1:0] REPORT_NONE = 2'd0;

    localparam logic [7:0] FLAG_BYTE = 8'h7e;

    // burst steps: 0..4 are the frame bytes, then the status report
    localparam logic [2:0] STEP_FLAG_OPEN  = 3'd0;
    localparam logic [2:0] STEP_ADDRESS    = 3'd1;
    localparam logic [2:0] STEP_CONTROL    = 3'd2;
    localparam logic [2:0] STEP_CHECK      = 3'd3;
    localparam logic [2:0] STEP_FLAG_CLOSE = 3'd4;
    localparam logic [2:0] STEP_REPORT     = 3'd5;

    typedef struct packed {
        logic        role;
        logic [15:0] timeout_ticks;
        logic [3:0]  max_tries;
        logic [7:0]  address_byte;
        logic [7:0]  control_byte;
    } cfg_t;

    // what one input item asks the output side to send
    typedef struct packed {
        logic       frame;   // five frame bytes
        logic [1:0] report;  // trailing status beat, or none
    } desc_t;

endpackage

### design/lsfh_core.sv
// ----------------------------------------------------------------------------
// lsfh_core: handshake state and frame recognizer
// Updates phase, recognizer step, tick count and try count on every accepted
// item and registers a burst descriptor for the output side.
// ----------------------------------------------------------------------------
module lsfh_core (
    input  logic            clk,
    input  logic            rst_n,
    input  lsfh_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      mode,
    input  logic [7:0]      rx_byte,
    output lsfh_pkg::desc_t desc,
    output logic            desc_valid,
    input  logic            desc_ready
);
    import lsfh_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_AWAIT  = 2'd1;
    localparam logic [1:0] PH_LISTEN = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  match_step_reg, match_step_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [3:0]  tries_reg, tries_next;
    desc_t       desc_reg, desc_next;
    logic        desc_valid_reg, desc_valid_next;

    logic        accept;
    logic        matched;
    logic [2:0]  rec_step;
    logic [15:0] tick_inc;
    logic [7:0]  check_byte;
    logic        has_beats;

    assign accept     = in_valid && in_ready;
    assign in_ready   = !desc_valid_reg || desc_ready;
    assign check_byte = cfg.address_byte ^ cfg.control_byte;
    assign tick_inc   = (ticks_reg == 16'hffff) ? ticks_reg : ticks_reg + 16'd1;

    // five-state recognizer
    always_comb
    begin
        matched  = 1'b0;
        rec_step = 3'd0;
        unique case (match_step_reg)
            STEP_FLAG_OPEN:
            begin
                rec_step = (rx_byte == FLAG_BYTE) ? STEP_ADDRESS : STEP_FLAG_OPEN;
            end
            STEP_ADDRESS:
            begin
                if (rx_byte == cfg.address_byte)
                    rec_step = STEP_CONTROL;
                else if (rx_byte == FLAG_BYTE)
                    rec_step = STEP_ADDRESS;
                else
                    rec_step = STEP_FLAG_OPEN;
            end
            STEP_CONTROL:
            begin
                if (rx_byte == cfg.control_byte)
                    rec_step = STEP_CHECK;
                else if (rx_byte == FLAG_BYTE)
                    rec_step = STEP_ADDRESS;
                else
                    rec_step = STEP_FLAG_OPEN;
            end
            STEP_CHECK:
            begin
                rec_step = (rx_byte == check_byte) ? STEP_FLAG_CLOSE : STEP_FLAG_OPEN;
            end
            STEP_FLAG_CLOSE:
            begin
                rec_step = STEP_FLAG_OPEN;
                matched  = (rx_byte == FLAG_BYTE);
            end
            default:
            begin
                rec_step = STEP_FLAG_OPEN;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        match_step_next = match_step_reg;
        ticks_next      = ticks_reg;
        tries_next      = tries_reg;
        desc_next       = '0;
        if (accept)
        begin
            unique case (mode)
                MODE_START:
                begin
                    match_step_next = STEP_FLAG_OPEN;
                    ticks_next      = '0;
                    if (cfg.role == ROLE_TX)
                    begin
                        tries_next     = 4'd1;
                        phase_next     = PH_AWAIT;
                        desc_next.frame = 1'b1;
                    end
                    else
                    begin
                        tries_next = '0;
                        phase_next = PH_LISTEN;
                    end
                end
                MODE_BYTE:
                begin
                    if (phase_reg == PH_AWAIT || phase_reg == PH_LISTEN)
                    begin
                        match_step_next = rec_step;
                        if (matched)
                        begin
                            desc_next.frame  = (phase_reg == PH_LISTEN);
                            desc_next.report = KIND_EST;
                            phase_next       = PH_IDLE;
                            ticks_next       = '0;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (phase_reg == PH_AWAIT)
                    begin
                        ticks_next = tick_inc;
                        if (tick_inc >= cfg.timeout_ticks)
                        begin
                            ticks_next      = '0;
                            match_step_next = STEP_FLAG_OPEN;
                            if (tries_reg >= cfg.max_tries)
                            begin
                                desc_next.report = KIND_FAIL;
                                phase_next       = PH_IDLE;
                            end
                            else
                            begin
                                tries_next      = tries_reg + 4'd1;
                                desc_next.frame = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // unused code: ignored
                end
            endcase
        end
    end

    assign has_beats = desc_next.frame || (desc_next.report != REPORT_NONE);

    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        if (accept)
            desc_valid_next = has_beats;
        else if (desc_ready)
            desc_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            match_step_reg <= STEP_FLAG_OPEN;
            ticks_reg      <= '0;
            tries_reg      <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            match_step_reg <= match_step_next;
            ticks_reg      <= ticks_next;
            tries_reg      <= tries_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            desc_reg <= desc_next;
    end

    assign desc       = desc_reg;
    assign desc_valid = desc_valid_reg;

    // a queued descriptor always asks for at least one beat
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> (desc_reg.frame || desc_reg.report != REPORT_NONE))
        else $error("empty burst descriptor queued");

    // tick count only runs while awaiting a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (ticks_reg == 16'd0))
        else $error("tick count nonzero while idle");

    // transmitter start always queues a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_START && cfg.role == ROLE_TX)
        |=> (desc_valid_reg && desc_reg.frame))
        else $error("start did not queue a frame");

endmodule

### design/lsfh_burst.sv
// ----------------------------------------------------------------------------
// lsfh_burst: result beat sequencer
// Expands a burst descriptor into frame bytes, a status beat or both, one
// beat per cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module lsfh_burst (
    input  logic            clk,
    input  logic            rst_n,
    input  lsfh_pkg::cfg_t  cfg,
    input  lsfh_pkg::desc_t desc,
    input  logic            desc_valid,
    output logic            desc_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      tx_byte,
    output logic            last
);
    import lsfh_pkg::*;

    desc_t      cur_reg;
    logic [2:0] step_reg;
    logic       busy_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] tx_byte_reg;
    logic       last_reg;

    logic [1:0] beat_kind;
    logic [7:0] beat_byte;
    logic       beat_last;
    logic       adv;
    logic       take;
    logic [2:0] first_step;

    always_comb
    begin
        beat_kind = KIND_TX;
        beat_byte = 8'h00;
        unique case (step_reg)
            STEP_FLAG_OPEN, STEP_FLAG_CLOSE: beat_byte = FLAG_BYTE;
            STEP_ADDRESS:                    beat_byte = cfg.address_byte;
            STEP_CONTROL:                    beat_byte = cfg.control_byte;
            STEP_CHECK:                      beat_byte = cfg.address_byte ^ cfg.control_byte;
            STEP_REPORT:                     beat_kind = cur_reg.report;
            default:                         beat_byte = 8'h00;
        endcase
    end

    assign beat_last  = (step_reg == STEP_REPORT) ||
                        (step_reg == STEP_FLAG_CLOSE && cur_reg.report == REPORT_NONE);
    assign adv        = busy_reg && (!out_valid_reg || out_ready);
    assign desc_ready = !busy_reg || (adv && beat_last);
    assign take       = desc_valid && desc_ready;
    assign first_step = desc.frame ? STEP_FLAG_OPEN : STEP_REPORT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_FLAG_OPEN;
        end
        else
        begin
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (take)
            begin
                busy_reg <= 1'b1;
                step_reg <= first_step;
            end
            else if (adv && beat_last)
                busy_reg <= 1'b0;
            else if (adv)
                step_reg <= step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= desc;
        if (adv)
        begin
            kind_reg    <= beat_kind;
            tx_byte_reg <= beat_byte;
            last_reg    <= beat_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= STEP_REPORT))
        else $error("burst step out of range");

    // a burst never pauses between its own beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !last_reg) |=> out_valid_reg)
        else $error("gap inside a burst");

endmodule

### design/link_setup_frame_handshake.sv
// ----------------------------------------------------------------------------
// link_setup_frame_handshake: serial link set-up handshake
// Sends, recognizes and echoes five-byte supervisory frames
// (flag, address, control, check, flag) with timeout and retries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, mode, rx_byte) carries one beat per
//   event: start handshake, a received serial byte, or one timer tick.
//   Output channel (out_valid/out_ready, kind, tx_byte, last) carries the
//   result beats: frame bytes to send, then link established or failed;
//   last marks the final beat caused by one input beat.
//   Configuration (cfg_we, cfg_index, cfg_data) writes role, timeout,
//   try limit, address and control bytes; write only while idle.
// Timing:
//   An input beat is taken every cycle while the descriptor register is free.
//   A result passes through the descriptor register, the sequencer's step
//   register and the output register; after that, one beat per cycle while
//   out_ready is high. The output sequencer sets the rate.
// Reset:
//   Handshake idle, recognizer hunting for the opening flag, counters zero,
//   registers at their defaults. No clearing pass.
// Stalls:
//   When out_ready is low, the current beat holds; up to two further
//   result-producing input beats are buffered (one in the sequencer, one in
//   the descriptor register), after which in_ready drops.
// ----------------------------------------------------------------------------
module link_setup_frame_handshake (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lsfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [7:0]                     tx_byte,
    output logic                           last
);
    import lsfh_pkg::*;

    cfg_t  cfg_reg;
    desc_t desc;
    logic  desc_valid;
    logic  desc_ready;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.role          <= ROLE_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.max_tries     <= MAX_TRY_RST;
            cfg_reg.address_byte  <= ADDRESS_RST;
            cfg_reg.control_byte  <= CONTROL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROLE:    cfg_reg.role          <= cfg_data[0];
                REG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data[15:0];
                REG_MAX_TRY: cfg_reg.max_tries     <= cfg_data[3:0];
                REG_ADDRESS: cfg_reg.address_byte  <= cfg_data[7:0];
                REG_CONTROL: cfg_reg.control_byte  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // state update and recognizer; one descriptor per result-producing beat
    lsfh_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready)
    );

    // expands descriptors into output beats
    lsfh_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .last       (last)
    );

endmodule

### verif/lsfh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfh_checker: result checker for the link set-up frame handshake
// Follows config writes and accepted input beats, predicts the result beats
// of each input beat, and compares every accepted result beat in order.
// ----------------------------------------------------------------------------
module lsfh_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lsfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [7:0]                      rx_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      tx_byte,
    input  logic                            last,
    output int                              pending,
    output int                              errors
);
    import lsfh_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       last;
    } result_beat_t;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_AWAIT_ECHO,
        LINK_LISTEN
    } link_phase_t;

    cfg_t         link_cfg;
    link_phase_t  link_phase;
    logic [2:0]   hunt_step;
    logic [15:0]  tick_count;
    logic [3:0]   tries;
    result_beat_t beat_results_q[$];
    result_beat_t link_results_q[$];
    int           mismatches;

    task automatic add_result(input logic [1:0] k, input logic [7:0] b);
        result_beat_t r;
        r.kind    = k;
        r.tx_byte = b;
        r.last    = 1'b0;
        beat_results_q.push_back(r);
    endtask

    task automatic add_frame();
        add_result(KIND_TX, FLAG_BYTE);
        add_result(KIND_TX, link_cfg.address_byte);
        add_result(KIND_TX, link_cfg.control_byte);
        add_result(KIND_TX, link_cfg.address_byte ^ link_cfg.control_byte);
        add_result(KIND_TX, FLAG_BYTE);
    endtask

    // frame recognizer; hit is set when the closing flag completes a frame
    task automatic advance_hunt(input logic [7:0] b, output logic hit);
        hit = 1'b0;
        case (hunt_step)
            STEP_FLAG_OPEN:
                if (b == FLAG_BYTE) hunt_step = STEP_ADDRESS;
            STEP_ADDRESS:
                if (b == link_cfg.address_byte) hunt_step = STEP_CONTROL;
                else if (b == FLAG_BYTE)        hunt_step = STEP_ADDRESS;
                else                            hunt_step = STEP_FLAG_OPEN;
            STEP_CONTROL:
                if (b == link_cfg.control_byte) hunt_step = STEP_CHECK;
                else if (b == FLAG_BYTE)        hunt_step = STEP_ADDRESS;
                else                            hunt_step = STEP_FLAG_OPEN;
            STEP_CHECK:
                if (b == (link_cfg.address_byte ^ link_cfg.control_byte))
                    hunt_step = STEP_FLAG_CLOSE;
                else
                    hunt_step = STEP_FLAG_OPEN;
            STEP_FLAG_CLOSE:
            begin
                hunt_step = STEP_FLAG_OPEN;
                hit       = (b == FLAG_BYTE);
            end
            default:
                hunt_step = STEP_FLAG_OPEN;
        endcase
    endtask

    task automatic step_handshake(input logic [1:0] m, input logic [7:0] b);
        logic         hit;
        result_beat_t r;
        beat_results_q.delete();
        case (m)
            MODE_START:
            begin
                hunt_step  = STEP_FLAG_OPEN;
                tick_count = '0;
                if (link_cfg.role == ROLE_TX)
                begin
                    tries      = 4'd1;
                    link_phase = LINK_AWAIT_ECHO;
                    add_frame();
                end
                else
                begin
                    tries      = 4'd0;
                    link_phase = LINK_LISTEN;
                end
            end
            MODE_BYTE:
            begin
                if (link_phase != LINK_IDLE)
                begin
                    advance_hunt(b, hit);
                    if (hit)
                    begin
                        if (link_phase == LINK_LISTEN) add_frame();
                        add_result(KIND_EST, 8'h00);
                        link_phase = LINK_IDLE;
                        tick_count = '0;
                    end
                end
            end
            MODE_TICK:
            begin
                if (link_phase == LINK_AWAIT_ECHO)
                begin
                    if (tick_count != 16'hffff) tick_count = tick_count + 16'd1;
                    if (tick_count >= link_cfg.timeout_ticks)
                    begin
                        tick_count = '0;
                        hunt_step  = STEP_FLAG_OPEN;
                        if (tries >= link_cfg.max_tries)
                        begin
                            add_result(KIND_FAIL, 8'h00);
                            link_phase = LINK_IDLE;
                        end
                        else
                        begin
                            tries = tries + 4'd1;
                            add_frame();
                        end
                    end
                end
            end
            default: ;
        endcase
        if (beat_results_q.size() > 0)
        begin
            r      = beat_results_q.pop_back();
            r.last = 1'b1;
            beat_results_q.push_back(r);
        end
        foreach (beat_results_q[i]) link_results_q.push_back(beat_results_q[i]);
    endtask

    task automatic report_mismatch(input bit have_exp, input result_beat_t exp_r,
                                   input result_beat_t got_r);
        if (mismatches < 10)
        begin
            if (have_exp)
                $display("[%0t] result mismatch: expected kind=%0d tx_byte=%02h last=%0d,",
                         $time, exp_r.kind, exp_r.tx_byte, exp_r.last,
                         " got kind=%0d tx_byte=%02h last=%0d",
                         got_r.kind, got_r.tx_byte, got_r.last);
            else
                $display("[%0t] unexpected result: kind=%0d tx_byte=%02h last=%0d",
                         $time, got_r.kind, got_r.tx_byte, got_r.last);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t got_r;
        result_beat_t exp_r;
        if (!rst_n)
        begin
            link_cfg.role          = ROLE_RST;
            link_cfg.timeout_ticks = TIMEOUT_RST;
            link_cfg.max_tries     = MAX_TRY_RST;
            link_cfg.address_byte  = ADDRESS_RST;
            link_cfg.control_byte  = CONTROL_RST;
            link_phase             = LINK_IDLE;
            hunt_step              = STEP_FLAG_OPEN;
            tick_count             = '0;
            tries                  = '0;
            link_results_q.delete();
            mismatches             = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_r.kind    = kind;
                got_r.tx_byte = tx_byte;
                got_r.last    = last;
                if (link_results_q.size() == 0)
                    report_mismatch(1'b0, got_r, got_r);
                else
                begin
                    exp_r = link_results_q.pop_front();
                    if (got_r.kind !== exp_r.kind || got_r.tx_byte !== exp_r.tx_byte ||
                        got_r.last !== exp_r.last)
                        report_mismatch(1'b1, exp_r, got_r);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROLE:    link_cfg.role          = cfg_data[0];
                    REG_TIMEOUT: link_cfg.timeout_ticks = cfg_data[15:0];
                    REG_MAX_TRY: link_cfg.max_tries     = cfg_data[3:0];
                    REG_ADDRESS: link_cfg.address_byte  = cfg_data[7:0];
                    REG_CONTROL: link_cfg.control_byte  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) step_handshake(mode, rx_byte);
            pending <= link_results_q.size();
            errors  <= mismatches;
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the link set-up frame handshake
// Drives start, byte and tick beats in random bursts against a stalling
// receiver, across a series of register settings, and leaves the checking
// of every result beat to lsfh_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lsfh_pkg::*;

    // mode code that the block ignores
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    // cycles to let an input beat with no results clear the pipe
    localparam int DRAIN_CYCLES        = 8;
    localparam int RANDOM_ITEMS        = 250;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            tx_byte;
    logic                  last;

    int pending;
    int errors;

    // sender burst state and running count of random beats
    int burst_left;
    int items_sent;

    // register values as last written, used to build well-formed frames
    logic        cur_role;
    logic [15:0] cur_timeout;
    logic [3:0]  cur_tries;
    logic [7:0]  cur_addr;
    logic [7:0]  cur_ctrl;

    // receiver stall pattern state
    int ready_style = 0;
    int ready_count = 0;
    int stall_left  = 0;

    link_setup_frame_handshake dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    lsfh_checker u_handshake_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .last      (last),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every beat at six results,
    // each result behind a long stall, plus all sender gaps and drains).
    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Receiver: a new stall style each time a random countdown runs out. Styles
    // are always ready, coin flip, a fixed 4-of-5 pattern, and rare long stalls.
    always @(posedge clk)
    begin
        if (ready_count == 0)
        begin
            ready_style <= $urandom_range(0, 3);
            ready_count <= $urandom_range(50, 200);
        end
        else
            ready_count <= ready_count - 1;
        case (ready_style)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= (ready_count % 5 != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    out_ready  <= 1'b0;
                    stall_left <= stall_left - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(5, 20);
                end
            end
        endcase
    end

    // One input beat. A fresh burst starts with a random gap (sometimes none),
    // so gaps land on every phase of the output sequencer. Returns at the
    // edge where the beat is taken.
    task automatic send_beat(input logic [1:0] m, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_counted(input logic [1:0] m, input logic [7:0] b);
        send_beat(m, b);
        items_sent++;
    endtask

    // Hold off until the checker has seen every predicted result, then give
    // a beat with no results time to leave the pipe.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // All five registers, one per cycle; only called while the block is idle.
    task automatic configure(input logic r, input logic [15:0] t, input logic [3:0] n,
                             input logic [7:0] a, input logic [7:0] c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROLE;
        cfg_data  <= CFG_DATA_W'(r);
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= t;
        @(posedge clk);
        cfg_index <= REG_MAX_TRY;
        cfg_data  <= CFG_DATA_W'(n);
        @(posedge clk);
        cfg_index <= REG_ADDRESS;
        cfg_data  <= CFG_DATA_W'(a);
        @(posedge clk);
        cfg_index <= REG_CONTROL;
        cfg_data  <= CFG_DATA_W'(c);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_role    = r;
        cur_timeout = t;
        cur_tries   = n;
        cur_addr    = a;
        cur_ctrl    = c;
    endtask

    // Bytes biased toward the ones the recognizer cares about.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return FLAG_BYTE;
            1:       return cur_addr;
            2:       return cur_ctrl;
            3:       return cur_addr ^ cur_ctrl;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_field(input logic [7:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return FLAG_BYTE;
            3:       return dflt;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Full frame as the echo; optionally one byte damaged.
    task automatic send_frame(input bit corrupt);
        logic [7:0] frame_bytes [5];
        int         bad_pos;
        frame_bytes[0] = FLAG_BYTE;
        frame_bytes[1] = cur_addr;
        frame_bytes[2] = cur_ctrl;
        frame_bytes[3] = cur_addr ^ cur_ctrl;
        frame_bytes[4] = FLAG_BYTE;
        if (corrupt)
        begin
            bad_pos              = $urandom_range(0, 4);
            frame_bytes[bad_pos] = frame_bytes[bad_pos] ^ 8'($urandom_range(1, 255));
        end
        foreach (frame_bytes[i]) send_counted(MODE_BYTE, frame_bytes[i]);
    endtask

    task automatic pick_config();
        logic        r;
        logic [15:0] t;
        logic [3:0]  n;
        r = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       t = 16'd0;
            1:       t = 16'hffff;
            2:       t = 16'($urandom_range(6, 65535));
            default: t = 16'($urandom_range(1, 5));
        endcase
        case ($urandom_range(0, 7))
            0:       n = 4'd0;
            1:       n = 4'd15;
            default: n = 4'($urandom_range(1, 4));
        endcase
        configure(r, t, n, pick_field(ADDRESS_RST), pick_field(CONTROL_RST));
    endtask

    // One exchange: mostly a full handshake with some noise in front, else
    // tick runs toward retry and failure, or a little pure noise.
    task automatic run_exchange();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
        begin
            send_counted(MODE_START, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2))
                send_counted(($urandom_range(0, 1) == 0) ? MODE_BYTE : MODE_TICK, pick_byte());
            // an extra opening flag must not throw the recognizer off
            if ($urandom_range(0, 3) == 0) send_counted(MODE_BYTE, FLAG_BYTE);
            send_frame($urandom_range(0, 4) == 0);
        end
        else if (pick <= 7)
        begin
            send_counted(MODE_START, 8'($urandom_range(0, 255)));
            n = ((cur_timeout == 0) ? 1 : int'(cur_timeout)) *
                ((cur_tries == 0) ? 1 : int'(cur_tries)) + 1;
            if (n > 40) n = int'($urandom_range(1, 40));
            repeat (n) send_counted(MODE_TICK, 8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        // now and then the sender waits for every result before going on
        if ($urandom_range(0, 19) == 0) settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ROLE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        mode        = MODE_START;
        rx_byte     = 8'h00;
        burst_left  = 0;
        items_sent  = 0;
        cur_role    = ROLE_RST;
        cur_timeout = TIMEOUT_RST;
        cur_tries   = MAX_TRY_RST;
        cur_addr    = ADDRESS_RST;
        cur_ctrl    = CONTROL_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, transmitter: frame out, echo back, established
        send_beat(MODE_START, 8'h00);
        send_beat(MODE_BYTE, FLAG_BYTE);
        send_beat(MODE_BYTE, ADDRESS_RST);
        send_beat(MODE_BYTE, CONTROL_RST);
        send_beat(MODE_BYTE, ADDRESS_RST ^ CONTROL_RST);
        send_beat(MODE_BYTE, FLAG_BYTE);
        // idle: byte, tick and the spare mode are all ignored
        send_beat(MODE_BYTE, 8'hff);
        send_beat(MODE_TICK, 8'h00);
        send_beat(MODE_SPARE, 8'h5a);
        settle();

        // zero timeout and zero tries: the first tick fails the link
        configure(ROLE_TX, 16'd0, 4'd0, 8'h00, 8'hff);
        send_beat(MODE_START, 8'hff);
        send_beat(MODE_TICK, 8'h00);
        settle();

        // start while busy restarts; one retransmit, then failure
        configure(ROLE_TX, 16'd1, 4'd2, 8'h00, 8'hff);
        send_beat(MODE_START, 8'h00);
        send_beat(MODE_START, 8'h00);
        send_beat(MODE_TICK, 8'hff);
        send_beat(MODE_TICK, 8'h00);
        settle();

        // receiver at register extremes: tick ignored, doubled flag, echo
        configure(ROLE_RX, 16'hffff, 4'd15, 8'hff, 8'h00);
        send_beat(MODE_START, 8'h00);
        send_beat(MODE_TICK, 8'hff);
        send_beat(MODE_BYTE, FLAG_BYTE);
        send_beat(MODE_BYTE, FLAG_BYTE);
        send_beat(MODE_BYTE, 8'hff);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'hff);
        send_beat(MODE_BYTE, FLAG_BYTE);
        settle();

        // random phases, each with its own register setting
        while (items_sent < RANDOM_ITEMS)
        begin
            pick_config();
            repeat ($urandom_range(3, 8)) run_exchange();
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### link_setup_frame_handshake.f
design/lsfh_pkg.sv
design/lsfh_core.sv
design/lsfh_burst.sv
design/link_setup_frame_handshake.sv
verif/lsfh_checker.sv
verif/tb_top.sv
